// ===== rtl/core/mvt4_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform unit.
// No dependencies; imported by the core and its checker.
package mvt4_pkg;

    localparam int DIM       = 4;
    localparam int IDX_W     = $clog2(DIM);
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CMD_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_ROW = 3'd0,
        CMD_WRITE_COL = 3'd1,
        CMD_READ_ROW  = 3'd2,
        CMD_READ_COL  = 3'd3,
        CMD_TRANSFORM = 3'd4
    } cmd_t;

    typedef logic signed [DATA_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// ===== rtl/core/matrix_vector_transform_4x4_unit.sv =====
// Top level of the 4x4 matrix-vector transform unit: matrix store, multiply,
// add and saturate pipeline. Depends on mvt4_pkg.

// The unit holds a 4x4 matrix of signed Q16.16 elements, zero after reset.
// Every cycle it can take one command: write a row or column, read a row or
// column, or transform the input vector by the matrix. A transfer on the input
// channel reaches the output through the input, product, pair-sum and output
// registers, and a new transfer is taken every cycle while the output keeps
// draining; throughput comes from sixteen parallel 32x32 multipliers, followed
// by one stage of pair sums and one stage of the final add, shift and saturate.
// Writes update the matrix in command order, so the very next command already
// sees them. Writes and unused command codes produce no output transfer.
module matrix_vector_transform_4x4_unit
    import mvt4_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic [IDX_W-1:0]         s_row_col_index,
    input  logic signed [DATA_W-1:0] s_vec_x,
    input  logic signed [DATA_W-1:0] s_vec_y,
    input  logic signed [DATA_W-1:0] s_vec_z,
    input  logic signed [DATA_W-1:0] s_vec_w,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_out_x,
    output logic signed [DATA_W-1:0] m_out_y,
    output logic signed [DATA_W-1:0] m_out_z,
    output logic signed [DATA_W-1:0] m_out_w
);

    elem_t mat_reg [DIM][DIM];

    logic             a_valid_reg;
    cmd_t             a_cmd_reg;
    logic [IDX_W-1:0] a_idx_reg;
    elem_t            a_vec_reg [DIM];

    logic  b_valid_reg;
    logic  b_read_reg;
    prod_t b_prod_reg [DIM][DIM];
    prod_t b_prod_next [DIM][DIM];
    elem_t b_rd_reg [DIM];
    elem_t b_rd_next [DIM];

    logic  c_valid_reg;
    logic  c_read_reg;
    pair_t c_pair_reg [DIM][2];
    pair_t c_pair_next [DIM][2];
    elem_t c_rd_reg [DIM];

    logic  d_valid_reg;
    elem_t d_out_reg [DIM];
    elem_t d_out_next [DIM];

    logic a_has_res;
    logic a_go;
    logic a_write_row;
    logic a_write_col;
    logic b_free;
    logic c_free;
    logic d_free;

    always_comb begin
        case (a_cmd_reg)
            CMD_READ_ROW, CMD_READ_COL, CMD_TRANSFORM: a_has_res = 1'b1;
            default:                                   a_has_res = 1'b0;
        endcase
    end

    assign a_write_row = (a_cmd_reg == CMD_WRITE_ROW);
    assign a_write_col = (a_cmd_reg == CMD_WRITE_COL);

    assign d_free  = !d_valid_reg || m_ready;
    assign c_free  = !c_valid_reg || d_free;
    assign b_free  = !b_valid_reg || c_free;
    assign a_go    = a_valid_reg && (!a_has_res || b_free);
    assign s_ready = !a_valid_reg || a_go;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_cmd_reg    <= cmd_t'(s_command);
            a_idx_reg    <= s_row_col_index;
            a_vec_reg[0] <= s_vec_x;
            a_vec_reg[1] <= s_vec_y;
            a_vec_reg[2] <= s_vec_z;
            a_vec_reg[3] <= s_vec_w;
        end
    end

    // matrix store, written in command order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    mat_reg[r][c] <= '0;
                end
            end
        end else if (a_go) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    if (a_write_row && (a_idx_reg == IDX_W'(r))) begin
                        mat_reg[r][c] <= a_vec_reg[c];
                    end else if (a_write_col && (a_idx_reg == IDX_W'(c))) begin
                        mat_reg[r][c] <= a_vec_reg[r];
                    end
                end
            end
        end
    end

    // products and read data
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                b_prod_next[r][c] = mat_reg[r][c] * a_vec_reg[c];
            end
        end
        for (int k = 0; k < DIM; k++) begin
            if (a_cmd_reg == CMD_READ_ROW) begin
                b_rd_next[k] = mat_reg[a_idx_reg][k];
            end else begin
                b_rd_next[k] = mat_reg[k][a_idx_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_go && a_has_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free && a_go && a_has_res) begin
            b_read_reg  <= (a_cmd_reg != CMD_TRANSFORM);
            b_prod_reg  <= b_prod_next;
            b_rd_reg    <= b_rd_next;
        end
    end

    // pair sums
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            c_pair_next[r][0] = PAIR_W'(b_prod_reg[r][0]) + PAIR_W'(b_prod_reg[r][1]);
            c_pair_next[r][1] = PAIR_W'(b_prod_reg[r][2]) + PAIR_W'(b_prod_reg[r][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_free) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_free && b_valid_reg) begin
            c_read_reg <= b_read_reg;
            c_pair_reg <= c_pair_next;
            c_rd_reg   <= b_rd_reg;
        end
    end

    // final add, shift and saturate
    always_comb begin
        sum_t total;
        sum_t shifted;
        for (int r = 0; r < DIM; r++) begin
            total   = SUM_W'(c_pair_reg[r][0]) + SUM_W'(c_pair_reg[r][1]);
            shifted = total >>> FRAC_BITS;
            if (c_read_reg) begin
                d_out_next[r] = c_rd_reg[r];
            end else if (&shifted[SUM_W-1:DATA_W-1] || !(|shifted[SUM_W-1:DATA_W-1])) begin
                d_out_next[r] = shifted[DATA_W-1:0];
            end else if (shifted[SUM_W-1]) begin
                d_out_next[r] = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                d_out_next[r] = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (d_free) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_free && c_valid_reg) begin
            d_out_reg <= d_out_next;
        end
    end

    assign m_valid = d_valid_reg;
    assign m_out_x = d_out_reg[0];
    assign m_out_y = d_out_reg[1];
    assign m_out_z = d_out_reg[2];
    assign m_out_w = d_out_reg[3];

endmodule

// ===== rtl/core/mvt4_checker.sv =====
// Port-level checker for the 4x4 matrix-vector transform unit, with its bind.
// Depends on mvt4_pkg and matrix_vector_transform_4x4_unit.
module mvt4_checker
    import mvt4_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [CMD_W-1:0]         s_command,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [DATA_W-1:0] m_out_x,
    input logic signed [DATA_W-1:0] m_out_y,
    input logic signed [DATA_W-1:0] m_out_z,
    input logic signed [DATA_W-1:0] m_out_w
);

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_res;
    logic       out_xfer;

    assign in_res = s_valid && s_ready &&
                    ((s_command == CMD_READ_ROW) || (s_command == CMD_READ_COL) ||
                     (s_command == CMD_TRANSFORM));
    assign out_xfer  = m_valid && m_ready;
    assign pend_next = pend_reg + 3'(in_res) - 3'(out_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
                                && $stable(m_out_z) && $stable(m_out_w))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> (pend_reg != 3'd0))
        else $error("result transfer without a pending command");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd4)
        else $error("more pending results than pipeline stages");

endmodule

bind matrix_vector_transform_4x4_unit mvt4_checker u_mvt4_checker (.*);
